### hdl/tcp_session_tracker_top_macros.svh
// Assertion macros for the session tracker.
`ifndef TCP_SESSION_TRACKER_TOP_MACROS_SVH
`define TCP_SESSION_TRACKER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that also holds during reset.
`define TST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### hdl/tst_pkg.sv
// Shared types and constants of the session tracker.
`timescale 1ns / 1ps
`default_nettype none
package tst_pkg;
  localparam logic [35:0] TimeoutReset = 36'd5000000000;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic OpPacket = 1'b0;
  localparam logic OpSweep = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic        syn_flag;
    logic        ack_flag;
    logic [15:0] payload_size;
    logic [63:0] now_time;
  } req_t;

  typedef struct packed {
    logic        record_valid;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [31:0] server_ip;
    logic [15:0] server_port;
    logic [47:0] bytes_sent;
    logic [47:0] bytes_received;
    logic [63:0] start_time;
    logic [63:0] end_time;
    logic        last;
  } rec_t;
endpackage
`default_nettype wire

### hdl/tst_if.sv
// Valid/ready channel interfaces of the session tracker.
`timescale 1ns / 1ps
`default_nettype none
interface tst_req_if;
  logic          valid;
  logic          ready;
  tst_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tst_rec_if;
  logic          valid;
  logic          ready;
  tst_pkg::rec_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tst_cfg_if;
  logic        valid;
  logic        ready;
  logic [35:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/tst_queue.sv
// Two-entry request queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module tst_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tst_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tst_pkg::req_t      out_data_o
);
  tst_pkg::req_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### hdl/tst_table.sv
// Session table back end: match, insert, update and expiry sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_session_tracker_top_macros.svh"
module tst_table #(
  parameter int TableDepth = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [35:0]   timeout_i,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire tst_pkg::req_t req_i,
  output logic               rec_valid_o,
  input  wire logic          rec_ready_i,
  output tst_pkg::rec_t      rec_o
);
  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW = $clog2(TableDepth + 1);
  localparam logic [1:0] StIdle = 2'd0, StMatch = 2'd1, StSweep = 2'd2, StMark = 2'd3;

  logic [1:0] state_q, state_d;
  logic [TableDepth-1:0] valid_q;
  logic [31:0] cip_q [TableDepth];
  logic [15:0] cpt_q [TableDepth];
  logic [31:0] sip_q [TableDepth];
  logic [15:0] spt_q [TableDepth];
  logic [47:0] snt_q [TableDepth];
  logic [47:0] rcv_q [TableDepth];
  logic [63:0] ft_q  [TableDepth];
  logic [63:0] lt_q  [TableDepth];

  tst_pkg::req_t cur_q;
  logic [CntW-1:0] idx_q;
  logic out_v_q;
  tst_pkg::rec_t out_q;

  // match vectors of the incoming request, registered at the accepting edge
  logic [TableDepth-1:0] fwd, rev, hit, hit_q, fromc_q, fromc;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic any_hit, any_free;

  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      fwd[i] = valid_q[i] && cip_q[i] == req_i.src_ip && cpt_q[i] == req_i.src_port &&
               sip_q[i] == req_i.dst_ip && spt_q[i] == req_i.dst_port;
      rev[i] = valid_q[i] && cip_q[i] == req_i.dst_ip && cpt_q[i] == req_i.dst_port &&
               sip_q[i] == req_i.src_ip && spt_q[i] == req_i.src_port;
      hit[i] = fwd[i] || rev[i];
      fromc[i] = cip_q[i] == req_i.src_ip && cpt_q[i] == req_i.src_port;
    end
  end

  always_comb begin
    hit_idx = '0;
    free_idx = '0;
    any_hit = 1'b0;
    any_free = 1'b0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IdxW'(i);
        any_hit = 1'b1;
      end
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
        any_free = 1'b1;
      end
    end
  end

  logic [IdxW-1:0] sidx;
  logic expired, out_free;
  logic [63:0] idle;
  logic [48:0] sum_s, sum_r;
  assign sidx = idx_q[IdxW-1:0];
  assign idle = cur_q.now_time - lt_q[sidx];
  assign expired = valid_q[sidx] && idle > {28'd0, timeout_i};
  assign out_free = !out_v_q || rec_ready_i;
  assign sum_s = {1'b0, snt_q[hit_idx]} + {33'd0, cur_q.payload_size};
  assign sum_r = {1'b0, rcv_q[hit_idx]} + {33'd0, cur_q.payload_size};

  assign req_ready_o = state_q == StIdle;
  assign rec_valid_o = out_v_q;
  assign rec_o = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (req_valid_i) state_d = (req_i.op == tst_pkg::OpSweep) ? StSweep : StMatch;
      StMatch: state_d = StIdle;
      StSweep: if (out_free && idx_q == CntW'(TableDepth - 1)) state_d = StMark;
      StMark:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      out_v_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_v_q && rec_ready_i) out_v_q <= 1'b0;
      if (state_q == StIdle && req_valid_i) idx_q <= '0;
      if (state_q == StMatch && !any_hit && cur_q.syn_flag && any_free)
        valid_q[free_idx] <= 1'b1;
      if (state_q == StSweep && out_free) begin
        if (expired) begin
          valid_q[sidx] <= 1'b0;
          out_v_q <= 1'b1;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (state_q == StMark && out_free) out_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req_valid_i) cur_q <= req_i;
    hit_q <= hit;
    fromc_q <= fromc;
    if (state_q == StMatch) begin
      if (any_hit) begin
        lt_q[hit_idx] <= cur_q.now_time;
        if (fromc_q[hit_idx]) snt_q[hit_idx] <= sum_s[48] ? tst_pkg::Max48 : sum_s[47:0];
        else rcv_q[hit_idx] <= sum_r[48] ? tst_pkg::Max48 : sum_r[47:0];
      end else if (cur_q.syn_flag && any_free) begin
        cip_q[free_idx] <= cur_q.ack_flag ? cur_q.dst_ip : cur_q.src_ip;
        cpt_q[free_idx] <= cur_q.ack_flag ? cur_q.dst_port : cur_q.src_port;
        sip_q[free_idx] <= cur_q.ack_flag ? cur_q.src_ip : cur_q.dst_ip;
        spt_q[free_idx] <= cur_q.ack_flag ? cur_q.src_port : cur_q.dst_port;
        snt_q[free_idx] <= '0;
        rcv_q[free_idx] <= '0;
        ft_q[free_idx] <= cur_q.now_time;
        lt_q[free_idx] <= cur_q.now_time;
      end
    end
    if (state_q == StSweep && out_free && expired) begin
      out_q.record_valid <= 1'b1;
      out_q.client_ip <= cip_q[sidx];
      out_q.client_port <= cpt_q[sidx];
      out_q.server_ip <= sip_q[sidx];
      out_q.server_port <= spt_q[sidx];
      out_q.bytes_sent <= snt_q[sidx];
      out_q.bytes_received <= rcv_q[sidx];
      out_q.start_time <= ft_q[sidx];
      out_q.end_time <= lt_q[sidx];
      out_q.last <= 1'b0;
    end
    if (state_q == StMark && out_free) out_q <= '{last: 1'b1, default: '0};
  end

  `TST_ASSERT(a_match_follows, clk_i, rst_ni,
    state_q == StMatch |-> $past(state_q) == StIdle, "match without request")
  `TST_ASSERT(a_out_hold, clk_i, rst_ni,
    out_v_q && !rec_ready_i |=> out_v_q && $stable(out_q), "record dropped")
  `TST_ASSERT(a_ready_idle, clk_i, rst_ni,
    req_ready_o |-> state_q == StIdle, "ready outside idle")
endmodule
`default_nettype wire

### hdl/tcp_session_tracker_top.sv
// Top level of the TCP session tracker.
//   channel  dir  payload
//   req_if   in   packet or sweep request
//   rec_if   out  expired session record or end marker
//   cfg_if   in   idle timeout, 36 bits
// In the back end a packet is accepted in the idle state, registering the
// parallel match over all slots, and then updated or inserted in StMatch.
// A sweep: accept, one slot per cycle while the output is free, then marker.
// The queue lets requests enter while the back end works.
// Reset clears slot valid bits and sets the timeout to 5000000000 ns.
`timescale 1ns / 1ps
`default_nettype none
module tcp_session_tracker_top #(
  parameter int TableDepth = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tst_req_if.sink   req_if,
  tst_rec_if.source rec_if,
  tst_cfg_if.sink   cfg_if
);
  logic [35:0] timeout_q;
  logic q_v, q_r;
  tst_pkg::req_t q_d;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) timeout_q <= tst_pkg::TimeoutReset;
    else if (cfg_if.valid) timeout_q <= cfg_if.data;
  end

  tst_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(req_if.valid), .in_ready_o(req_if.ready), .in_data_i(req_if.data),
    .out_valid_o(q_v), .out_ready_i(q_r), .out_data_o(q_d)
  );

  tst_table #(.TableDepth(TableDepth)) u_table (
    .clk_i, .rst_ni, .timeout_i(timeout_q),
    .req_valid_i(q_v), .req_ready_o(q_r), .req_i(q_d),
    .rec_valid_o(rec_if.valid), .rec_ready_i(rec_if.ready), .rec_o(rec_if.data)
  );
endmodule
`default_nettype wire
